// ===== hdl/jada_pkg.sv =====
package jada_pkg;

  localparam int SAMPLE_BITS  = 12;
  localparam int AVG_LEN      = 10;
  localparam int CORDIC_STEPS = 14;

  localparam int SUM_W   = 16;
  localparam int CNT_W   = 4;
  localparam int DZ_W    = 26;
  localparam int ANGLE_W = 16;
  localparam int STEP_W  = 5;

  // sum / AVG_LEN as a multiply by a rounded-up reciprocal and a shift
  localparam int RECIP_SHIFT = 19;
  localparam int RECIP_W     = 16;
  localparam int AVG_RECIP   = ((1 << RECIP_SHIFT) + AVG_LEN - 1) / AVG_LEN;
  localparam int PROD_W      = SUM_W + RECIP_W;

  localparam int DELTA_W = SAMPLE_BITS + 1;
  localparam int DSQ_W   = 2 * DELTA_W;

  localparam int CORDIC_SCALE = 16;
  localparam int CW           = SAMPLE_BITS + CORDIC_SCALE + 3;

  localparam int HALF_PI_Q13 = 12868;
  localparam int PI_Q13      = 25736;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = DZ_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER_X    = 2'd0,
    CFG_CENTER_Y    = 2'd1,
    CFG_DEADZONE_SQ = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic             valid;
    logic [SUM_W-1:0] sum_x;
    logic [SUM_W-1:0] sum_y;
  } sum_beat_t;

  typedef struct packed {
    logic                      valid;
    logic                      moving;
    logic [SAMPLE_BITS-1:0]    avg_x;
    logic [SAMPLE_BITS-1:0]    avg_y;
    logic signed [CW-1:0]      x;
    logic signed [CW-1:0]      y;
    logic signed [ANGLE_W-1:0] z;
  } cordic_beat_t;

  // atan(2^-i) in Q3.13, rounded to nearest
  function automatic logic signed [ANGLE_W-1:0] atan_q13(input logic [STEP_W-1:0] i);
    logic signed [ANGLE_W-1:0] v;
    case (i)
      5'd0:    v = 16'sd6434;
      5'd1:    v = 16'sd3798;
      5'd2:    v = 16'sd2007;
      5'd3:    v = 16'sd1019;
      5'd4:    v = 16'sd511;
      5'd5:    v = 16'sd256;
      5'd6:    v = 16'sd128;
      5'd7:    v = 16'sd64;
      5'd8:    v = 16'sd32;
      5'd9:    v = 16'sd16;
      5'd10:   v = 16'sd8;
      5'd11:   v = 16'sd4;
      5'd12:   v = 16'sd2;
      5'd13:   v = 16'sd1;
      default: v = 16'sd0;
    endcase
    return v;
  endfunction

endpackage

// ===== hdl/jada_if.sv =====
interface jada_in_if;
  logic                             valid;
  logic                             ready;
  logic [jada_pkg::SAMPLE_BITS-1:0] sample_x;
  logic [jada_pkg::SAMPLE_BITS-1:0] sample_y;

  modport source (output valid, output sample_x, output sample_y, input ready);
  modport sink   (input valid, input sample_x, input sample_y, output ready);
endinterface

interface jada_out_if;
  logic                                valid;
  logic                                ready;
  logic                                moving;
  logic signed [jada_pkg::ANGLE_W-1:0] angle;
  logic [jada_pkg::SAMPLE_BITS-1:0]    avg_x;
  logic [jada_pkg::SAMPLE_BITS-1:0]    avg_y;

  modport source (output valid, output moving, output angle, output avg_x, output avg_y,
                  input ready);
  modport sink   (input valid, input moving, input angle, input avg_x, input avg_y,
                  output ready);
endinterface

interface jada_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [jada_pkg::CFG_IDX_W-1:0]  index;
  logic [jada_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/jada_accum.sv =====
module jada_accum (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  jada_in_if.sink             in_ch,
  output jada_pkg::sum_beat_t sum_beat
);
  import jada_pkg::*;

  logic [SUM_W-1:0] sum_x_r, sum_x_nxt;
  logic [SUM_W-1:0] sum_y_r, sum_y_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             beat_valid_r;
  logic [SUM_W-1:0] out_x_r, out_y_r;
  logic             last;
  logic             accept;
  logic [SUM_W-1:0] add_x, add_y;

  assign last   = (count_r == CNT_W'(AVG_LEN - 1));
  // the closing pair of a block needs room in the pipeline; take nothing in reset
  assign in_ch.ready = rst_n && (!last || adv);
  assign accept = in_ch.valid && in_ch.ready;

  assign add_x = sum_x_r + SUM_W'(in_ch.sample_x);
  assign add_y = sum_y_r + SUM_W'(in_ch.sample_y);

  always_comb begin
    sum_x_nxt = sum_x_r;
    sum_y_nxt = sum_y_r;
    count_nxt = count_r;
    if (accept) begin
      if (last) begin
        sum_x_nxt = '0;
        sum_y_nxt = '0;
        count_nxt = '0;
      end else begin
        sum_x_nxt = add_x;
        sum_y_nxt = add_y;
        count_nxt = count_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_x_r      <= '0;
      sum_y_r      <= '0;
      count_r      <= '0;
      beat_valid_r <= 1'b0;
    end else begin
      sum_x_r <= sum_x_nxt;
      sum_y_r <= sum_y_nxt;
      count_r <= count_nxt;
      if (adv) begin
        beat_valid_r <= accept && last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_x_r <= add_x;
      out_y_r <= add_y;
    end
  end

  assign sum_beat.valid = beat_valid_r;
  assign sum_beat.sum_x = out_x_r;
  assign sum_beat.sum_y = out_y_r;

`ifndef ASSERT_OFF
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r < CNT_W'(AVG_LEN))
    else $error("block count past its length");

  a_block_clear: assert property (@(posedge clk) disable iff (!rst_n)
    accept && last |=> sum_x_r == '0 && sum_y_r == '0 && count_r == '0 && beat_valid_r)
    else $error("block end did not clear sums or launch a beat");
`endif

endmodule

// ===== hdl/jada_front.sv =====
module jada_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                adv,
  input  jada_pkg::sum_beat_t                 sum_beat,
  input  logic [jada_pkg::SAMPLE_BITS-1:0]    center_x,
  input  logic [jada_pkg::SAMPLE_BITS-1:0]    center_y,
  input  logic [jada_pkg::DZ_W-1:0]           deadzone_sq,
  output jada_pkg::cordic_beat_t              cell_beat
);
  import jada_pkg::*;

  // average
  logic [PROD_W-1:0]      prod_x, prod_y;
  logic                   v1_r;
  logic [SAMPLE_BITS-1:0] ax1_r, ay1_r;

  // deltas and squares
  logic signed [DELTA_W-1:0] dx_nxt, dy_nxt;
  logic signed [DSQ_W-1:0]   sqx_nxt, sqy_nxt;
  logic                      v2_r;
  logic [SAMPLE_BITS-1:0]    ax2_r, ay2_r;
  logic signed [DELTA_W-1:0] dx2_r, dy2_r;
  logic signed [DSQ_W-1:0]   sqx2_r, sqy2_r;

  // compare and pre-rotation
  logic [DSQ_W:0]            rad_sq;
  logic signed [CW-1:0]      dx_w, dy_w;
  logic signed [CW-1:0]      x0_nxt, y0_nxt;
  logic signed [ANGLE_W-1:0] z0_nxt;
  logic                      v3_r;
  cordic_beat_t              beat3_r;

  assign prod_x = PROD_W'(sum_beat.sum_x) * PROD_W'(AVG_RECIP);
  assign prod_y = PROD_W'(sum_beat.sum_y) * PROD_W'(AVG_RECIP);

  assign dx_nxt  = $signed({1'b0, center_x}) - $signed({1'b0, ax1_r});
  assign dy_nxt  = $signed({1'b0, ay1_r}) - $signed({1'b0, center_y});
  assign sqx_nxt = DSQ_W'(dx_nxt) * DSQ_W'(dx_nxt);
  assign sqy_nxt = DSQ_W'(dy_nxt) * DSQ_W'(dy_nxt);

  assign rad_sq = {1'b0, $unsigned(sqx2_r)} + {1'b0, $unsigned(sqy2_r)};
  assign dx_w   = CW'(dx2_r) <<< CORDIC_SCALE;
  assign dy_w   = CW'(dy2_r) <<< CORDIC_SCALE;

  // turn the vector into the right half plane
  always_comb begin
    x0_nxt = dx_w;
    y0_nxt = dy_w;
    z0_nxt = '0;
    if (dx2_r < 0) begin
      if (dy2_r >= 0) begin
        x0_nxt = dy_w;
        y0_nxt = -dx_w;
        z0_nxt = ANGLE_W'(HALF_PI_Q13);
      end else begin
        x0_nxt = -dy_w;
        y0_nxt = dx_w;
        z0_nxt = -ANGLE_W'(HALF_PI_Q13);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v1_r <= sum_beat.valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ax1_r <= prod_x[RECIP_SHIFT +: SAMPLE_BITS];
      ay1_r <= prod_y[RECIP_SHIFT +: SAMPLE_BITS];

      ax2_r  <= ax1_r;
      ay2_r  <= ay1_r;
      dx2_r  <= dx_nxt;
      dy2_r  <= dy_nxt;
      sqx2_r <= sqx_nxt;
      sqy2_r <= sqy_nxt;

      beat3_r.valid  <= 1'b0;
      beat3_r.moving <= rad_sq > {1'b0, deadzone_sq};
      beat3_r.avg_x  <= ax2_r;
      beat3_r.avg_y  <= ay2_r;
      beat3_r.x      <= x0_nxt;
      beat3_r.y      <= y0_nxt;
      beat3_r.z      <= z0_nxt;
    end
  end

  always_comb begin
    cell_beat       = beat3_r;
    cell_beat.valid = v3_r;
  end

endmodule

// ===== hdl/jada_cordic_cell.sv =====
module jada_cordic_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        adv,
  input  logic [jada_pkg::STEP_W-1:0] step,
  input  jada_pkg::cordic_beat_t      beat_in,
  output jada_pkg::cordic_beat_t      beat_out
);
  import jada_pkg::*;

  logic signed [CW-1:0]      x_in, y_in, xs, ys;
  logic signed [ANGLE_W-1:0] z_in, rot;
  cordic_beat_t              nxt;
  cordic_beat_t              data_r;
  logic                      valid_r;

  assign x_in = beat_in.x;
  assign y_in = beat_in.y;
  assign z_in = beat_in.z;
  assign xs   = x_in >>> step;
  assign ys   = y_in >>> step;
  assign rot  = atan_q13(step);

  // one vectoring micro-rotation: drive y toward zero
  always_comb begin
    nxt = beat_in;
    if (y_in > 0) begin
      nxt.x = x_in + ys;
      nxt.y = y_in - xs;
      nxt.z = z_in + rot;
    end else begin
      nxt.x = x_in - ys;
      nxt.y = y_in + xs;
      nxt.z = z_in - rot;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= beat_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      data_r <= nxt;
    end
  end

  always_comb begin
    beat_out       = data_r;
    beat_out.valid = valid_r;
  end

endmodule

// ===== hdl/joystick_average_deadzone_angle_top.sv =====
// A result for the pair that closes a block of ten passes, once that pair is accepted, through
// the sum register, three front stages, one cell per CORDIC step and the output register.
// Throughput: one pair per cycle (closing pairs wait out stalls); one result per ten pairs.
// The pipeline advances only while the output register is empty or being taken.
// Reset (rst_n low, synchronous) clears sums, count and all beat-valid flags and loads
// center_x = center_y = 2050 and deadzone_sq = 1000000.
module joystick_average_deadzone_angle_top (
  input  logic        clk,
  input  logic        rst_n,
  jada_in_if.sink     in_ch,
  jada_out_if.source  out_ch,
  jada_cfg_if.sink    cfg_ch
);
  import jada_pkg::*;

  logic [SAMPLE_BITS-1:0] center_x_r, center_y_r;
  logic [DZ_W-1:0]        deadzone_sq_r;

  logic                      adv;
  sum_beat_t                 sum_beat;
  cordic_beat_t              cell_bus [CORDIC_STEPS+1];
  cordic_beat_t              tail;
  logic signed [ANGLE_W-1:0] z_sat;

  logic                      out_valid_r;
  logic                      out_moving_r;
  logic signed [ANGLE_W-1:0] out_angle_r;
  logic [SAMPLE_BITS-1:0]    out_avg_x_r, out_avg_y_r;

  // configuration; hold off writes in reset
  assign cfg_ch.ready = rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r    <= SAMPLE_BITS'(2050);
      center_y_r    <= SAMPLE_BITS'(2050);
      deadzone_sq_r <= DZ_W'(1000 * 1000);
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_CENTER_X:    center_x_r    <= cfg_ch.data[SAMPLE_BITS-1:0];
        CFG_CENTER_Y:    center_y_r    <= cfg_ch.data[SAMPLE_BITS-1:0];
        CFG_DEADZONE_SQ: deadzone_sq_r <= cfg_ch.data[DZ_W-1:0];
        default: ;
      endcase
    end
  end

  assign adv = !out_valid_r || out_ch.ready;

  jada_accum u_accum (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_ch    (in_ch),
    .sum_beat (sum_beat)
  );

  jada_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (adv),
    .sum_beat    (sum_beat),
    .center_x    (center_x_r),
    .center_y    (center_y_r),
    .deadzone_sq (deadzone_sq_r),
    .cell_beat   (cell_bus[0])
  );

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
    jada_cordic_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .step     (STEP_W'(g)),
      .beat_in  (cell_bus[g]),
      .beat_out (cell_bus[g+1])
    );
  end

  assign tail = cell_bus[CORDIC_STEPS];

  always_comb begin
    z_sat = tail.z;
    if (tail.z > ANGLE_W'(PI_Q13)) begin
      z_sat = ANGLE_W'(PI_Q13);
    end else if (tail.z < -ANGLE_W'(PI_Q13)) begin
      z_sat = -ANGLE_W'(PI_Q13);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= tail.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_moving_r <= tail.moving;
      out_angle_r  <= tail.moving ? z_sat : '0;
      out_avg_x_r  <= tail.avg_x;
      out_avg_y_r  <= tail.avg_y;
    end
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.moving = out_moving_r;
  assign out_ch.angle  = out_angle_r;
  assign out_ch.avg_x  = out_avg_x_r;
  assign out_ch.avg_y  = out_avg_y_r;

`ifndef ASSERT_OFF
  a_still_zero_angle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_moving_r |-> out_angle_r == '0)
    else $error("angle nonzero inside dead zone");

  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_angle_r <= PI_Q13 && out_angle_r >= -PI_Q13)
    else $error("angle outside saturation range");
`endif

endmodule
